[rtl/core/cbc_pkg.sv]
`timescale 1ns / 1ps
// cbc_pkg: constants, codes and types of the cell balance controller.
// No dependencies.

package cbc_pkg;

    localparam int NUM_CELLS  = 16;
    localparam int CELL_IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int MASK_W     = 16;
    localparam int VOLT_W     = 16;
    localparam int TIME_W     = 32;
    localparam int FUNC_W     = 2;
    localparam int IN_IDX_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PHASE_W    = 2;

    typedef logic [FUNC_W-1:0]     func_t;
    typedef logic [CELL_IDX_W-1:0] cell_idx_t;
    typedef logic [VOLT_W-1:0]     volt_t;
    typedef logic [TIME_W-1:0]     time_t;

    localparam func_t FUNC_WRITE = 2'd0;
    localparam func_t FUNC_START = 2'd1;
    localparam func_t FUNC_STOP  = 2'd2;
    localparam func_t FUNC_TICK  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_START_FLOOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXCESS_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_FACTOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_CYCLES = 2'd3;

    localparam volt_t RST_START_FLOOR = 16'd3900;
    localparam volt_t RST_EXCESS_THR  = 16'd10;
    localparam volt_t RST_TIME_FACTOR = 16'd100;
    localparam volt_t RST_WAIT_CYCLES = 16'd1000;
    localparam volt_t RST_TARGET      = 16'hFFFF;

    localparam logic [PHASE_W-1:0] PHASE_LAST = 2'd2;

endpackage

[rtl/core/cell_balance_controller.sv]
`timescale 1ns / 1ps
// cell_balance_controller: passive cell balancer with a per-cell sequencer.
// Depends on cbc_pkg.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+---------------------------------------------
//  input     | in_valid / in_ready      | func, cell_index, cell_voltage, lowest_voltage
//  result    | out_valid / out_ready    | enable_mask, mask_valid, any_enabled,
//            |                          | cycle_length, active, start_refused, times_fresh
//  config    | cfg_we                   | cfg_index, cfg_data
//
// Sequencing, with the output register free: an accepted start runs subtract, multiply
// and max per cell, then the sum; a refreshing tick visits one cell per cycle; other
// items go straight to the output state.
// A new item is taken while the previous result still waits in the output register.
// A stalled result holds the sequencer in its output state until that register frees.
// Reset clears all cell voltages and times; no clearing pass is needed.

module cell_balance_controller
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [cbc_pkg::FUNC_W-1:0]         func,
    input  logic [cbc_pkg::IN_IDX_W-1:0]       cell_index,
    input  logic [cbc_pkg::VOLT_W-1:0]         cell_voltage,
    input  logic [cbc_pkg::VOLT_W-1:0]         lowest_voltage,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cbc_pkg::MASK_W-1:0]         enable_mask,
    output logic                               mask_valid,
    output logic                               any_enabled,
    output logic [cbc_pkg::TIME_W-1:0]         cycle_length,
    output logic                               active,
    output logic                               start_refused,
    output logic                               times_fresh
);
    import cbc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXC  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_MAX  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_TICK = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam cell_idx_t LAST_IDX = CELL_IDX_W'(NUM_CELLS - 1);

    logic [2:0]          state_reg;
    cell_idx_t           idx_reg;
    volt_t               floor_reg;
    volt_t               thr_reg;
    volt_t               factor_reg;
    volt_t               wait_reg;
    volt_t               volt_reg [NUM_CELLS];
    time_t               time_reg [NUM_CELLS];
    volt_t               target_reg;
    logic                bal_on_reg;
    logic [PHASE_W-1:0]  phase_reg;
    time_t               total_reg;
    logic                computed_reg;
    volt_t               exc_reg;
    logic                pass_reg;
    time_t               prod_reg;
    time_t               longest_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic                valid_flag_reg;
    logic                refused_reg;

    logic                out_valid_reg;
    logic [MASK_W-1:0]   out_mask_reg;
    logic                out_mvalid_reg;
    logic                out_any_reg;
    time_t               out_total_reg;
    logic                out_active_reg;
    logic                out_refused_reg;
    logic                out_fresh_reg;

    logic                in_xfer;
    logic                out_free;
    logic                out_load;
    volt_t               cur_volt;
    time_t               cur_time;
    time_t               tick_time;
    logic [TIME_W:0]     sum_wide;
    cell_idx_t           wr_idx;
    logic                wr_in_range;

    assign in_ready    = (state_reg == S_IDLE);
    assign in_xfer     = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign out_load    = (state_reg == S_OUT) && out_free;
    assign cur_volt    = volt_reg[idx_reg];
    assign cur_time    = time_reg[idx_reg];
    assign tick_time   = (cur_volt <= target_reg) ? '0 : cur_time;
    assign sum_wide    = {1'b0, longest_reg} + {{(TIME_W + 1 - VOLT_W){1'b0}}, wait_reg};
    assign wr_idx      = CELL_IDX_W'(cell_index);
    assign wr_in_range = (32'(cell_index) < NUM_CELLS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            floor_reg      <= RST_START_FLOOR;
            thr_reg        <= RST_EXCESS_THR;
            factor_reg     <= RST_TIME_FACTOR;
            wait_reg       <= RST_WAIT_CYCLES;
            for (int i = 0; i < NUM_CELLS; i++)
            begin
                volt_reg[i] <= '0;
                time_reg[i] <= '0;
            end
            target_reg     <= RST_TARGET;
            bal_on_reg     <= 1'b0;
            phase_reg      <= '0;
            total_reg      <= '0;
            computed_reg   <= 1'b0;
            exc_reg        <= '0;
            pass_reg       <= 1'b0;
            prod_reg       <= '0;
            longest_reg    <= '0;
            mask_reg       <= '0;
            valid_flag_reg <= 1'b0;
            refused_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_START_FLOOR: floor_reg  <= cfg_data;
                    REG_EXCESS_THR:  thr_reg    <= cfg_data;
                    REG_TIME_FACTOR: factor_reg <= cfg_data;
                    REG_WAIT_CYCLES: wait_reg   <= cfg_data;
                    default: ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        mask_reg       <= '0;
                        valid_flag_reg <= 1'b0;
                        refused_reg    <= 1'b0;
                        idx_reg        <= '0;
                        longest_reg    <= '0;
                        state_reg      <= S_OUT;
                        unique case (func)
                            FUNC_WRITE:
                            begin
                                if (wr_in_range)
                                begin
                                    volt_reg[wr_idx] <= cell_voltage;
                                end
                            end
                            FUNC_START:
                            begin
                                if (lowest_voltage < floor_reg)
                                begin
                                    refused_reg <= 1'b1;
                                end
                                else
                                begin
                                    bal_on_reg <= 1'b1;
                                    target_reg <= lowest_voltage;
                                    state_reg  <= S_EXC;
                                end
                            end
                            FUNC_STOP:
                            begin
                                bal_on_reg <= 1'b0;
                            end
                            FUNC_TICK:
                            begin
                                if (phase_reg == '0)
                                begin
                                    valid_flag_reg <= 1'b1;
                                    state_reg      <= S_TICK;
                                end
                                phase_reg <= (phase_reg >= PHASE_LAST) ? '0 : phase_reg + 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_EXC:
                begin
                    exc_reg   <= (cur_volt > target_reg) ? (cur_volt - target_reg) : '0;
                    pass_reg  <= (cur_volt > target_reg) && ((cur_volt - target_reg) > thr_reg);
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg  <= pass_reg ? (TIME_W'(exc_reg) * TIME_W'(factor_reg)) : '0;
                    state_reg <= S_MAX;
                end
                S_MAX:
                begin
                    time_reg[idx_reg] <= prod_reg;
                    if (prod_reg > longest_reg)
                    begin
                        longest_reg <= prod_reg;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_SUM;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_EXC;
                    end
                end
                S_SUM:
                begin
                    total_reg    <= sum_wide[TIME_W] ? '1 : sum_wide[TIME_W-1:0];
                    computed_reg <= 1'b1;
                    state_reg    <= S_OUT;
                end
                S_TICK:
                begin
                    time_reg[idx_reg] <= tick_time;
                    if ((tick_time != '0) && (32'(idx_reg) < MASK_W))
                    begin
                        mask_reg <= mask_reg | (MASK_W'(1) << idx_reg);
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result payload, loaded when the output slot takes a new transfer
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_mask_reg    <= mask_reg;
            out_mvalid_reg  <= valid_flag_reg;
            out_any_reg     <= (mask_reg != '0);
            out_total_reg   <= total_reg;
            out_active_reg  <= bal_on_reg;
            out_refused_reg <= refused_reg;
            out_fresh_reg   <= computed_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign enable_mask   = out_mask_reg;
    assign mask_valid    = out_mvalid_reg;
    assign any_enabled   = out_any_reg;
    assign cycle_length  = out_total_reg;
    assign active        = out_active_reg;
    assign start_refused = out_refused_reg;
    assign times_fresh   = out_fresh_reg;

`ifndef SYNTHESIS
    a_any_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (any_enabled == (enable_mask != '0)))
        else $error("any_enabled disagrees with enable_mask");

    a_mask_only_on_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !mask_valid) |-> (enable_mask == '0))
        else $error("mask set on a step without refresh");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PHASE_LAST)
        else $error("tick phase out of range");

    a_start_turns_on: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (func == FUNC_START) && (lowest_voltage >= floor_reg)) |=> bal_on_reg)
        else $error("accepted start did not turn balancing on");
`endif

endmodule

[tb/balance_scoreboard.sv]
`timescale 1ns / 1ps
// balance_scoreboard: predicts each cell_balance_controller result and compares it.
// Depends on cbc_pkg; instantiated beside the DUT by cell_balance_controller_tb.

module balance_scoreboard
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [cbc_pkg::FUNC_W-1:0]         func,
    input  logic [cbc_pkg::IN_IDX_W-1:0]       cell_index,
    input  logic [cbc_pkg::VOLT_W-1:0]         cell_voltage,
    input  logic [cbc_pkg::VOLT_W-1:0]         lowest_voltage,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [cbc_pkg::MASK_W-1:0]         enable_mask,
    input  logic                               mask_valid,
    input  logic                               any_enabled,
    input  logic [cbc_pkg::TIME_W-1:0]         cycle_length,
    input  logic                               active,
    input  logic                               start_refused,
    input  logic                               times_fresh,
    output int                                 fail_count,
    output int                                 results_owed
);

    import cbc_pkg::*;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              refreshed;
        logic              any_on;
        time_t             cycle_len;
        logic              is_active;
        logic              refused;
        logic              fresh;
    } balance_result_t;

    volt_t              cell_volts [NUM_CELLS];
    time_t              bleed_time [NUM_CELLS];
    volt_t              target;
    logic               bal_on;
    logic [PHASE_W-1:0] phase;
    time_t              cycle_total;
    logic               computed;

    volt_t              floor_v;
    volt_t              excess_thr;
    volt_t              factor;
    volt_t              wait_len;

    balance_result_t    owed_q [$];
    int                 mismatch_total;

    function automatic balance_result_t predict_balance(input func_t f,
                                                        input logic [IN_IDX_W-1:0] idx,
                                                        input volt_t v,
                                                        input volt_t low);
        balance_result_t r;
        volt_t           excess;
        time_t           t;
        time_t           longest;
        logic [TIME_W:0] sum;
        r = '0;
        case (f)
            FUNC_WRITE:
            begin
                if (int'(idx) < NUM_CELLS)
                    cell_volts[idx] = v;
            end
            FUNC_START:
            begin
                if (low < floor_v)
                    r.refused = 1'b1;
                else
                begin
                    bal_on  = 1'b1;
                    target  = low;
                    longest = '0;
                    for (int c = 0; c < NUM_CELLS; c++)
                    begin
                        excess = (cell_volts[c] > target) ? cell_volts[c] - target : '0;
                        if (excess > excess_thr)
                        begin
                            t = time_t'(excess) * time_t'(factor);
                            bleed_time[c] = t;
                            if (t > longest)
                                longest = t;
                        end
                        else
                            bleed_time[c] = '0;
                    end
                    sum = {1'b0, longest} + (TIME_W+1)'(wait_len);
                    cycle_total = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                    computed = 1'b1;
                end
            end
            FUNC_STOP:
            begin
                bal_on = 1'b0;
            end
            default:
            begin
                if (phase == '0)
                begin
                    r.refreshed = 1'b1;
                    for (int c = 0; c < NUM_CELLS; c++)
                    begin
                        if (cell_volts[c] <= target)
                            bleed_time[c] = '0;
                        if (bleed_time[c] != '0 && c < MASK_W)
                            r.mask[c] = 1'b1;
                    end
                end
                phase = (phase >= PHASE_LAST) ? '0 : phase + 1'b1;
            end
        endcase
        r.any_on    = |r.mask;
        r.cycle_len = cycle_total;
        r.is_active = bal_on;
        r.fresh     = computed;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t %s: expected %0h, got %0h", $time, field, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        balance_result_t want;
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CELLS; c++)
            begin
                cell_volts[c] = '0;
                bleed_time[c] = '0;
            end
            target         = RST_TARGET;
            bal_on         = 1'b0;
            phase          = '0;
            cycle_total    = '0;
            computed       = 1'b0;
            floor_v        = RST_START_FLOOR;
            excess_thr     = RST_EXCESS_THR;
            factor         = RST_TIME_FACTOR;
            wait_len       = RST_WAIT_CYCLES;
            owed_q.delete();
            mismatch_total = 0;
            fail_count   <= 0;
            results_owed <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_START_FLOOR: floor_v    = cfg_data;
                    REG_EXCESS_THR:  excess_thr = cfg_data;
                    REG_TIME_FACTOR: factor     = cfg_data;
                    REG_WAIT_CYCLES: wait_len   = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (owed_q.size() == 0)
                begin
                    $display("%0t result transfer: expected none, got mask %0h cycle %0h",
                             $time, enable_mask, cycle_length);
                    mismatch_total++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    check_field("enable_mask", 32'(want.mask), 32'(enable_mask));
                    check_field("mask_valid", 32'(want.refreshed), 32'(mask_valid));
                    check_field("any_enabled", 32'(want.any_on), 32'(any_enabled));
                    check_field("cycle_length", want.cycle_len, cycle_length);
                    check_field("active", 32'(want.is_active), 32'(active));
                    check_field("start_refused", 32'(want.refused), 32'(start_refused));
                    check_field("times_fresh", 32'(want.fresh), 32'(times_fresh));
                end
            end
            if (in_valid && in_ready)
                owed_q.push_back(predict_balance(func_t'(func), cell_index,
                                                 cell_voltage, lowest_voltage));
            fail_count   <= mismatch_total;
            results_owed <= owed_q.size();
        end
    end

endmodule

[tb/cell_balance_controller_tb.sv]
`timescale 1ns / 1ps
// cell_balance_controller_tb: stimulus, receiver stalls and verdict for the balancer.
// Depends on cbc_pkg, cell_balance_controller and balance_scoreboard.

module cell_balance_controller_tb;

    import cbc_pkg::*;

    typedef logic [IN_IDX_W-1:0] cell_sel_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    func_t                 func;
    cell_sel_t             cell_index;
    volt_t                 cell_voltage;
    volt_t                 lowest_voltage;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [MASK_W-1:0]     enable_mask;
    logic                  mask_valid;
    logic                  any_enabled;
    time_t                 cycle_length;
    logic                  active;
    logic                  start_refused;
    logic                  times_fresh;

    int                    fail_count;
    int                    results_owed;
    int                    burst_left;
    volt_t                 floor_now;
    logic [1:0]            stall_mode;
    int                    stall_span;

    cell_balance_controller DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .cell_index     (cell_index),
        .cell_voltage   (cell_voltage),
        .lowest_voltage (lowest_voltage),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .enable_mask    (enable_mask),
        .mask_valid     (mask_valid),
        .any_enabled    (any_enabled),
        .cycle_length   (cycle_length),
        .active         (active),
        .start_refused  (start_refused),
        .times_fresh    (times_fresh)
    );

    balance_scoreboard u_balance_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .cell_index     (cell_index),
        .cell_voltage   (cell_voltage),
        .lowest_voltage (lowest_voltage),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .enable_mask    (enable_mask),
        .mask_valid     (mask_valid),
        .any_enabled    (any_enabled),
        .cycle_length   (cycle_length),
        .active         (active),
        .start_refused  (start_refused),
        .times_fresh    (times_fresh),
        .fail_count     (fail_count),
        .results_owed   (results_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: switches at random between always-ready, random and rarely-ready stall modes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_mode <= 2'd0;
            stall_span <= 0;
        end
        else
        begin
            if (stall_span == 0)
            begin
                stall_mode <= 2'($urandom_range(0, 2));
                stall_span <= $urandom_range(20, 200);
            end
            else
                stall_span <= stall_span - 1;
            case (stall_mode)
                2'd0:    out_ready <= 1'b1;
                2'd1:    out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    task automatic send_item(input func_t f, input cell_sel_t idx, input volt_t v,
                             input volt_t low);
        int gap;
        int r;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            r = $urandom_range(0, 9);
            if (r < 4)
                gap = 0;
            else if (r < 8)
                gap = $urandom_range(1, 5);
            else if (r < 9)
                gap = $urandom_range(6, 20);
            else
                gap = $urandom_range(21, 60);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid       <= 1'b1;
        func           <= f;
        cell_index     <= idx;
        cell_voltage   <= v;
        lowest_voltage <= low;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic wait_quiet();
        in_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input volt_t fl, input volt_t thr, input volt_t fac,
                                input volt_t wt);
        cfg_we    <= 1'b1;
        cfg_index <= REG_START_FLOOR;
        cfg_data  <= fl;
        @(posedge clk);
        cfg_index <= REG_EXCESS_THR;
        cfg_data  <= thr;
        @(posedge clk);
        cfg_index <= REG_TIME_FACTOR;
        cfg_data  <= fac;
        @(posedge clk);
        cfg_index <= REG_WAIT_CYCLES;
        cfg_data  <= wt;
        @(posedge clk);
        cfg_we    <= 1'b0;
        floor_now  = fl;
    endtask

    // mostly write/start/tick sequences around a pack level, some raw noise
    task automatic run_traffic(input int n);
        int    sent;
        int    r;
        int    level;
        volt_t base;
        volt_t v;
        volt_t low_v;
        volt_t lowest_seen;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                base = ($urandom_range(0, 3) == 0) ? volt_t'($urandom_range(0, 65535))
                                                   : volt_t'($urandom_range(3000, 4300));
                lowest_seen = '1;
                repeat ($urandom_range(1, 16))
                begin
                    level = int'(base) + $urandom_range(0, 400);
                    v = (level > 65535) ? 16'hFFFF : volt_t'(level);
                    send_item(FUNC_WRITE, cell_sel_t'($urandom), v, volt_t'($urandom));
                    if (v < lowest_seen)
                        lowest_seen = v;
                    sent++;
                end
                r = $urandom_range(0, 9);
                if (r < 5)
                    low_v = lowest_seen;
                else if (r < 7)
                    low_v = base;
                else if (r < 8)
                    low_v = floor_now;
                else if (r < 9)
                    low_v = floor_now - 1'b1;
                else
                    low_v = volt_t'($urandom);
                send_item(FUNC_START, cell_sel_t'($urandom), volt_t'($urandom), low_v);
                sent++;
                repeat ($urandom_range(1, 7))
                begin
                    send_item(FUNC_TICK, cell_sel_t'($urandom), volt_t'($urandom),
                              volt_t'($urandom));
                    sent++;
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    send_item(FUNC_STOP, cell_sel_t'($urandom), volt_t'($urandom),
                              volt_t'($urandom));
                    sent++;
                end
            end
            else
            begin
                send_item(func_t'($urandom_range(0, 3)), cell_sel_t'($urandom),
                          volt_t'($urandom), volt_t'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        func           = FUNC_WRITE;
        cell_index     = '0;
        cell_voltage   = '0;
        lowest_voltage = '0;
        burst_left     = 0;
        floor_now      = RST_START_FLOOR;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values
        send_item(FUNC_TICK, '0, '0, '0);
        send_item(FUNC_START, '0, '0, 16'd3899);
        send_item(FUNC_WRITE, 4'd0, 16'd0, 16'hFFFF);
        send_item(FUNC_WRITE, 4'd15, 16'hFFFF, 16'd0);
        send_item(FUNC_WRITE, 4'd5, 16'd4200, 16'd0);
        send_item(FUNC_WRITE, 4'd7, 16'd3910, 16'd0);
        send_item(FUNC_WRITE, 4'd8, 16'd3911, 16'd0);
        send_item(FUNC_START, 4'd15, 16'hFFFF, 16'd3900);
        send_item(FUNC_START, '0, '0, 16'd3905);
        repeat (4) send_item(FUNC_TICK, '0, '0, '0);
        send_item(FUNC_STOP, '0, '0, '0);
        repeat (3) send_item(FUNC_TICK, 4'hF, 16'hFFFF, 16'hFFFF);
        send_item(FUNC_WRITE, 4'd15, 16'd3905, 16'd0);
        repeat (3) send_item(FUNC_TICK, '0, '0, '0);
        send_item(FUNC_START, '0, '0, 16'hFFFF);
        send_item(FUNC_WRITE, 4'd3, 16'h8000, 16'hFFFF);
        wait_quiet();

        write_config('0, '0, '0, '0);
        run_traffic(200);
        wait_quiet();

        write_config('1, '1, '1, '1);
        run_traffic(200);
        wait_quiet();

        // longest possible bleed time plus longest wait
        write_config('0, '0, '1, '1);
        send_item(FUNC_WRITE, 4'd0, 16'hFFFF, 16'd0);
        send_item(FUNC_START, '0, '0, 16'd0);
        send_item(FUNC_TICK, '0, '0, '0);
        run_traffic(200);
        wait_quiet();

        write_config(RST_START_FLOOR, RST_EXCESS_THR, RST_TIME_FACTOR, RST_WAIT_CYCLES);
        run_traffic(250);
        wait_quiet();

        repeat (4)
        begin
            write_config(volt_t'($urandom_range(0, 4300)),
                         ($urandom_range(0, 3) == 0) ? volt_t'($urandom)
                                                     : volt_t'($urandom_range(0, 200)),
                         volt_t'($urandom), volt_t'($urandom));
            run_traffic(250);
            wait_quiet();
        end

        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("%0t timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
